// File: hw/rtl/pingpong_audio_playout_defines.svh
// Assertion macros used by the playout RTL file.
`ifndef PINGPONG_AUDIO_PLAYOUT_DEFINES_SVH
`define PINGPONG_AUDIO_PLAYOUT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define PPAP_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ppap assertion failed");
// Check that a condition never occurs outside reset.
`define PPAP_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("ppap forbidden condition seen");
`else
`define PPAP_ASSERT(name, prop)
`define PPAP_NEVER(name, cond)
`endif

`endif

// File: hw/rtl/ppap_pkg.sv
package ppap_pkg;

  // Request codes carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_TICK = 2'd1,
    REQ_STOP = 2'd2
  } req_t;

  // Buffer selector used for the play lock and the fill target.
  typedef enum logic [1:0] {
    BUF_NONE = 2'd0,
    BUF_A    = 2'd1,
    BUF_B    = 2'd2
  } buf_sel_t;

  // Register index of the fill enable register.
  localparam int unsigned REG_FILL_ENABLE = 0;

  // One result word, last field in the lowest bits.
  typedef struct packed {
    logic       b_ready;
    logic       a_ready;
    logic       load_accepted;
    logic       buffer_emptied;
    logic       played_buffer;
    logic [7:0] second_byte;
    logic [7:0] first_byte;
    logic       sample_valid;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// File: hw/rtl/pingpong_audio_playout.sv
// Ping-pong audio playout buffer.
// Input stream: tuser is the request (load byte, sample tick, stop), tdata the
// byte to load and tlast ends the current fill. Loads go to the buffer in
// fill, else the first empty one, A before B; a fill ends on tlast or when full,
// and the buffer then turns ready. Each tick plays two bytes from the locked
// ready buffer. Every input word yields exactly one output word.
// Output stream: tdata packs the result fields, see the port comment.
// Configuration: one APB register, fill_enable at address 0, reset to one.
// From input acceptance to output tvalid, a word passes the state update and
// the registered buffer reads in the read stage, then the output register.
// One word is taken per cycle as long as the output side drains.
// When the receiver stalls, the output register and the read stage hold their
// words and tready drops only once both are full.
// Reset clears flags, counts, pointers and the lock; no clearing pass runs.
// The buffer memories keep their contents: a tick only uses bytes below
// the byte count, and those were all written by the fill that set the count.
// A stop word flushes the same control state and keeps fill_enable.
`include "pingpong_audio_playout_defines.svh"

module pingpong_audio_playout
  import ppap_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] load_byte
  input  logic [1:0]             s_axis_tuser,   // [1:0] req_type
  input  logic                   s_axis_tlast,   // load_last
  // Output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] sample_valid, [8:1] first_byte, [16:9] second_byte, [17] played_buffer,
  // [18] buffer_emptied, [19] load_accepted, [20] a_ready, [21] b_ready,
  // [23:22] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic                   paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned CW = $clog2(BUF_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);

  // Buffer memories
  logic [7:0] store_a [BUF_DEPTH];
  logic [7:0] store_b [BUF_DEPTH];

  // Control state
  logic          fill_enable;
  logic          ready_a, ready_b;
  logic [CW-1:0] count_a, count_b;
  logic [CW-1:0] play_pos;
  buf_sel_t      play_lock;
  buf_sel_t      fill_target;
  logic [CW-1:0] fill_ptr;

  logic          ready_a_next, ready_b_next;
  logic [CW-1:0] count_a_next, count_b_next;
  logic [CW-1:0] play_pos_next;
  buf_sel_t      play_lock_next;
  buf_sel_t      fill_target_next;
  logic [CW-1:0] fill_ptr_next;

  // Handshake and pipeline registers
  logic    in_acc;
  logic    s1_adv;
  logic    s1_valid;
  result_t s1_res;
  logic    s1_first_ok, s1_second_ok, s1_sel_b;
  result_t res_next;
  logic    first_ok, second_ok, sel_b;
  result_t out_res;
  result_t out_comb;

  // Memory access signals
  logic          wr_a, wr_b;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr0, rd_addr1;
  logic [7:0]    rd_a0, rd_a1, rd_b0, rd_b1;

  // Load and tick helpers
  buf_sel_t      load_tgt;
  logic [CW-1:0] ptr_eff;
  logic [CW-1:0] ptr_inc;
  buf_sel_t      tick_sel;
  logic [CW-1:0] tick_cnt;
  logic [CW:0]   pos_p1, pos_p2;

  assign s1_adv        = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == 1'(REG_FILL_ENABLE)) ? {31'b0, fill_enable} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 paddr == 1'(REG_FILL_ENABLE)) begin
      fill_enable <= pwdata[0];
    end
  end

  // Buffer selection for loads and ticks
  always_comb begin
    if (fill_target == BUF_A && !ready_a) begin
      load_tgt = BUF_A;
    end else if (fill_target == BUF_B && !ready_b) begin
      load_tgt = BUF_B;
    end else if (!ready_a) begin
      load_tgt = BUF_A;
    end else if (!ready_b) begin
      load_tgt = BUF_B;
    end else begin
      load_tgt = BUF_NONE;
    end
    ptr_eff = (load_tgt != fill_target || fill_ptr >= DEPTH_C) ? '0 : fill_ptr;
    ptr_inc = ptr_eff + CW'(1);

    if (ready_a && play_lock != BUF_B) begin
      tick_sel = BUF_A;
      tick_cnt = count_a;
    end else if (ready_b && play_lock != BUF_A) begin
      tick_sel = BUF_B;
      tick_cnt = count_b;
    end else begin
      tick_sel = BUF_NONE;
      tick_cnt = '0;
    end
    pos_p1 = {1'b0, play_pos} + (CW+1)'(1);
    pos_p2 = {1'b0, play_pos} + (CW+1)'(2);
  end

  assign wr_addr  = ptr_eff[AW-1:0];
  assign rd_addr0 = play_pos[AW-1:0];
  assign rd_addr1 = pos_p1[AW-1:0];

  // Next state and result for the word at the input
  always_comb begin
    ready_a_next     = ready_a;
    ready_b_next     = ready_b;
    count_a_next     = count_a;
    count_b_next     = count_b;
    play_pos_next    = play_pos;
    play_lock_next   = play_lock;
    fill_target_next = fill_target;
    fill_ptr_next    = fill_ptr;
    res_next         = '0;
    wr_a             = 1'b0;
    wr_b             = 1'b0;
    rd_en            = 1'b0;
    first_ok         = 1'b0;
    second_ok        = 1'b0;
    sel_b            = 1'b0;
    case (s_axis_tuser)
      REQ_LOAD: begin
        if (fill_enable && load_tgt != BUF_NONE) begin
          res_next.load_accepted = 1'b1;
          wr_a = in_acc && load_tgt == BUF_A;
          wr_b = in_acc && load_tgt == BUF_B;
          if (s_axis_tlast || ptr_inc >= DEPTH_C) begin
            // Fill ends: the buffer turns ready with its byte count.
            if (load_tgt == BUF_A) begin
              ready_a_next = 1'b1;
              count_a_next = ptr_inc;
            end else begin
              ready_b_next = 1'b1;
              count_b_next = ptr_inc;
            end
            fill_target_next = BUF_NONE;
            fill_ptr_next    = '0;
          end else begin
            fill_target_next = load_tgt;
            fill_ptr_next    = ptr_inc;
          end
        end
      end
      REQ_TICK: begin
        if (tick_sel != BUF_NONE) begin
          rd_en                 = in_acc;
          sel_b                 = tick_sel == BUF_B;
          first_ok              = play_pos < tick_cnt;
          second_ok             = pos_p1 < {1'b0, tick_cnt};
          res_next.sample_valid  = 1'b1;
          res_next.played_buffer = sel_b;
          play_lock_next         = tick_sel;
          play_pos_next          = pos_p2[CW-1:0];
          if (pos_p2 >= {1'b0, tick_cnt}) begin
            // Buffer played out: free it and drop the lock.
            if (tick_sel == BUF_A) begin
              ready_a_next = 1'b0;
            end else begin
              ready_b_next = 1'b0;
            end
            play_pos_next           = '0;
            play_lock_next          = BUF_NONE;
            res_next.buffer_emptied = 1'b1;
          end
        end
      end
      REQ_STOP: begin
        ready_a_next     = 1'b0;
        ready_b_next     = 1'b0;
        count_a_next     = '0;
        count_b_next     = '0;
        play_pos_next    = '0;
        play_lock_next   = BUF_NONE;
        fill_target_next = BUF_NONE;
        fill_ptr_next    = '0;
      end
      default: begin
      end
    endcase
    res_next.a_ready = ready_a_next;
    res_next.b_ready = ready_b_next;
  end

  // Control state update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_a     <= 1'b0;
      ready_b     <= 1'b0;
      count_a     <= '0;
      count_b     <= '0;
      play_pos    <= '0;
      play_lock   <= BUF_NONE;
      fill_target <= BUF_NONE;
      fill_ptr    <= '0;
    end else if (in_acc) begin
      ready_a     <= ready_a_next;
      ready_b     <= ready_b_next;
      count_a     <= count_a_next;
      count_b     <= count_b_next;
      play_pos    <= play_pos_next;
      play_lock   <= play_lock_next;
      fill_target <= fill_target_next;
      fill_ptr    <= fill_ptr_next;
    end
  end

  // Buffer A: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_a) begin
      store_a[wr_addr] <= s_axis_tdata;
    end
    if (rd_en) begin
      rd_a0 <= store_a[rd_addr0];
      rd_a1 <= store_a[rd_addr1];
    end
  end

  // Buffer B: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_b) begin
      store_b[wr_addr] <= s_axis_tdata;
    end
    if (rd_en) begin
      rd_b0 <= store_b[rd_addr0];
      rd_b1 <= store_b[rd_addr1];
    end
  end

  // Read stage: holds the result while the buffer reads complete
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res       <= res_next;
      s1_first_ok  <= first_ok;
      s1_second_ok <= second_ok;
      s1_sel_b     <= sel_b;
    end
  end

  // Merge read data; bytes past the count read as zero
  always_comb begin
    out_comb            = s1_res;
    out_comb.first_byte  = s1_first_ok ? (s1_sel_b ? rd_b0 : rd_a0) : 8'd0;
    out_comb.second_byte = s1_second_ok ? (s1_sel_b ? rd_b1 : rd_a1) : 8'd0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= out_comb;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'(out_res);

  // A locked buffer is always ready.
  `PPAP_NEVER(lock_a_needs_ready, play_lock == BUF_A && !ready_a)
  `PPAP_NEVER(lock_b_needs_ready, play_lock == BUF_B && !ready_b)
  // A buffer being filled is never ready.
  `PPAP_NEVER(fill_target_not_ready,
              (fill_target == BUF_A && ready_a) || (fill_target == BUF_B && ready_b))
  // The play position stays below the byte count of the locked buffer.
  `PPAP_ASSERT(play_pos_in_range,
               play_lock != BUF_NONE |->
                 play_pos < ((play_lock == BUF_A) ? count_a : count_b))
  // With the output stalled and the read stage full, no word is taken.
  `PPAP_ASSERT(stall_blocks_input,
               (m_axis_tvalid && !m_axis_tready && s1_valid) |-> !s_axis_tready)

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ppap_pkg::*;

  localparam int unsigned PCM_DEPTH = 256;
  localparam int unsigned PCM_AW = $clog2(PCM_DEPTH);
  localparam int unsigned CYCLE_LIMIT = 200_000;
  // Request code that the block ignores.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Byte address of the fill_enable register on the narrow address bus.
  localparam logic FILL_ENABLE_ADDR = 1'(4 * REG_FILL_ENABLE);
  localparam int N_DIRECTED = 27;
  localparam int unsigned ROW_AW = $clog2(N_DIRECTED);

  typedef enum bit {ROW_WORD, ROW_SET_FILL} row_kind_t;

  // One directed step: an input word, or a new fill_enable value held in flag.
  typedef struct {
    row_kind_t  kind;
    logic [1:0] req;
    logic [7:0] data;
    logic       flag;
    bit         typed;
    result_t    want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;   // [7:0] load_byte
  logic [1:0]             s_axis_tuser = '0;   // [1:0] req_type
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [0] sample_valid, [8:1] first_byte, [16:9] second_byte, [17] played_buffer,
  // [18] buffer_emptied, [19] load_accepted, [20] a_ready, [21] b_ready
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic                   paddr = 1'b0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  pingpong_audio_playout #(.BUF_DEPTH(PCM_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  // Mirror of the playout state, updated as each input word is accepted.
  logic [7:0]  pcm_a [PCM_DEPTH] = '{default: 8'h00};
  logic [7:0]  pcm_b [PCM_DEPTH] = '{default: 8'h00};
  bit          rdy_a = 1'b0;
  bit          rdy_b = 1'b0;
  int unsigned cnt_a = 0;
  int unsigned cnt_b = 0;
  int unsigned play_pos = 0;
  buf_sel_t    lock = BUF_NONE;
  buf_sel_t    fill_tgt = BUF_NONE;
  int unsigned fill_ptr = 0;
  bit          fill_en = 1'b1;

  result_t       pending_words [$];
  directed_row_t directed_rows [N_DIRECTED];
  result_t       seen_word, due_word;
  bit            quiet = 1'b0;
  int unsigned   mismatches = 0;
  int unsigned   cycles = 0;
  int unsigned   words_sent = 0;
  int unsigned   words_checked = 0;
  int unsigned   pairs_played = 0;
  int unsigned   buffers_freed = 0;

  // Computes the output word for one input word and advances the mirror state.
  function automatic result_t next_playout_word(logic [1:0] req, logic [7:0] data,
                                                logic fill_last);
    result_t     r;
    buf_sel_t    sel;
    int unsigned cnt;
    r = '0;
    sel = BUF_NONE;
    case (req)
      REQ_LOAD: begin
        // A fill in progress keeps its buffer; otherwise A is tried before B.
        if (fill_en) begin
          if (fill_tgt == BUF_A && !rdy_a) sel = BUF_A;
          else if (fill_tgt == BUF_B && !rdy_b) sel = BUF_B;
          else if (!rdy_a) sel = BUF_A;
          else if (!rdy_b) sel = BUF_B;
        end
        if (sel != BUF_NONE) begin
          if (sel != fill_tgt) fill_ptr = 0;
          if (sel == BUF_A) pcm_a[PCM_AW'(fill_ptr)] = data;
          else pcm_b[PCM_AW'(fill_ptr)] = data;
          fill_ptr++;
          if (fill_last || fill_ptr >= PCM_DEPTH) begin
            if (sel == BUF_A) begin
              rdy_a = 1'b1;
              cnt_a = fill_ptr;
            end else begin
              rdy_b = 1'b1;
              cnt_b = fill_ptr;
            end
            fill_tgt = BUF_NONE;
            fill_ptr = 0;
          end else begin
            fill_tgt = sel;
          end
          r.load_accepted = 1'b1;
        end
      end
      REQ_TICK: begin
        // The locked buffer plays on; with no lock, A goes before B.
        if (rdy_a && lock != BUF_B) sel = BUF_A;
        else if (rdy_b && lock != BUF_A) sel = BUF_B;
        if (sel != BUF_NONE) begin
          lock = sel;
          cnt = (sel == BUF_A) ? cnt_a : cnt_b;
          r.sample_valid = 1'b1;
          if (play_pos < cnt)
            r.first_byte = (sel == BUF_A) ? pcm_a[PCM_AW'(play_pos)]
                                          : pcm_b[PCM_AW'(play_pos)];
          if (play_pos + 1 < cnt)
            r.second_byte = (sel == BUF_A) ? pcm_a[PCM_AW'(play_pos + 1)]
                                           : pcm_b[PCM_AW'(play_pos + 1)];
          r.played_buffer = (sel == BUF_B);
          play_pos += 2;
          if (play_pos >= cnt) begin
            if (sel == BUF_A) rdy_a = 1'b0;
            else rdy_b = 1'b0;
            play_pos = 0;
            lock = BUF_NONE;
            r.buffer_emptied = 1'b1;
          end
        end
      end
      REQ_STOP: begin
        rdy_a = 1'b0;
        rdy_b = 1'b0;
        cnt_a = 0;
        cnt_b = 0;
        play_pos = 0;
        lock = BUF_NONE;
        fill_tgt = BUF_NONE;
        fill_ptr = 0;
      end
      default: ;
    endcase
    r.a_ready = rdy_a;
    r.b_ready = rdy_b;
    return r;
  endfunction

  // Output word that carries only the load flag and the two ready flags.
  function automatic result_t flags_only(bit accepted, bit a_rdy, bit b_rdy);
    result_t r;
    r = '0;
    r.load_accepted = accepted;
    r.a_ready = a_rdy;
    r.b_ready = b_rdy;
    return r;
  endfunction

  function automatic int unsigned draw_wait();
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Offers one input word after a random gap and records what it should produce.
  task automatic send_word(input logic [1:0] req, input logic [7:0] data,
                           input logic fill_last, input bit typed = 1'b0,
                           input result_t typed_word = '0);
    int unsigned gap;
    result_t     predicted;
    gap = draw_wait();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= data;
    s_axis_tlast <= fill_last;
    do @(posedge clk); while (!s_axis_tready);
    predicted = next_playout_word(req, data, fill_last);
    pending_words.push_back(typed ? typed_word : predicted);
    words_sent++;
  endtask

  // Lets the block run dry so that a register write finds it idle.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes fill_enable over the register port and reads it back.
  task automatic program_fill_enable(input bit value);
    settle();
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= FILL_ENABLE_ADDR;
    pwdata <= {31'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    fill_en = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== {31'b0, value}) begin
      $error("fill_enable readback: expected %0h, got %0h", value, prdata);
      mismatches++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly whole fills of random length mixed with ticks, plus some stops,
  // unused request codes and fills cut short or run on.
  task automatic play_random(input int unsigned n_words, input bit start_full);
    int unsigned left;
    int unsigned r;
    bit          full_run;
    bit          ending;
    left = start_full ? PCM_DEPTH : 0;
    full_run = start_full;
    for (int unsigned i = 0; i < n_words; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_word(REQ_STOP, 8'($urandom), 1'($urandom));
      end else if (r < 4) begin
        send_word(REQ_UNUSED, 8'($urandom), 1'($urandom));
      end else if (r < 62) begin
        if (left == 0) begin
          full_run = ($urandom_range(0, 59) == 0);
          left = full_run ? PCM_DEPTH : $urandom_range(1, 12);
        end
        ending = !full_run && left == 1;
        if ($urandom_range(0, 19) == 0) ending = !ending;
        send_word(REQ_LOAD, 8'($urandom), ending);
        left--;
      end else begin
        send_word(REQ_TICK, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // Compare every output word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_word = result_t'(m_axis_tdata[RESULT_W-1:0]);
      if (pending_words.size() == 0) begin
        $error("output word %0h with nothing expected", m_axis_tdata);
        mismatches++;
      end else begin
        due_word = pending_words.pop_front();
        check_field("sample_valid", 8'(due_word.sample_valid),
                    8'(seen_word.sample_valid));
        check_field("first_byte", due_word.first_byte, seen_word.first_byte);
        check_field("second_byte", due_word.second_byte, seen_word.second_byte);
        check_field("played_buffer", 8'(due_word.played_buffer),
                    8'(seen_word.played_buffer));
        check_field("buffer_emptied", 8'(due_word.buffer_emptied),
                    8'(seen_word.buffer_emptied));
        check_field("load_accepted", 8'(due_word.load_accepted),
                    8'(seen_word.load_accepted));
        check_field("a_ready", 8'(due_word.a_ready), 8'(seen_word.a_ready));
        check_field("b_ready", 8'(due_word.b_ready), 8'(seen_word.b_ready));
        check_field("padding", '0, 8'(m_axis_tdata[OUT_TDATA_W-1:RESULT_W]));
        words_checked++;
        if (seen_word.sample_valid) pairs_played++;
        if (seen_word.buffer_emptied) buffers_freed++;
      end
    end
  end

  // Receiver: may drop tready for a random stall before taking each word.
  initial begin
    int unsigned stall;
    @(negedge rst);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    directed_row_t row;
    // Directed steps: fill A then B, a refused load, odd counts, the lock
    // holding B over a ready A, a stop mid-fill, and loads with filling off.
    directed_rows = '{
      '{ROW_WORD,     REQ_TICK,   8'h00, 1'b0, 1'b1, flags_only(1'b0, 1'b0, 1'b0)},
      '{ROW_WORD,     REQ_UNUSED, 8'hFF, 1'b1, 1'b1, flags_only(1'b0, 1'b0, 1'b0)},
      '{ROW_WORD,     REQ_LOAD,   8'h00, 1'b0, 1'b1, flags_only(1'b1, 1'b0, 1'b0)},
      '{ROW_WORD,     REQ_LOAD,   8'hFF, 1'b0, 1'b1, flags_only(1'b1, 1'b0, 1'b0)},
      '{ROW_WORD,     REQ_LOAD,   8'hA5, 1'b1, 1'b1, flags_only(1'b1, 1'b1, 1'b0)},
      '{ROW_WORD,     REQ_LOAD,   8'h5A, 1'b1, 1'b1, flags_only(1'b1, 1'b1, 1'b1)},
      '{ROW_WORD,     REQ_LOAD,   8'h11, 1'b0, 1'b1, flags_only(1'b0, 1'b1, 1'b1)},
      '{ROW_WORD,     REQ_TICK,   8'h00, 1'b0, 1'b0, '0},
      '{ROW_WORD,     REQ_TICK,   8'hFF, 1'b1, 1'b0, '0},
      '{ROW_WORD,     REQ_TICK,   8'h00, 1'b0, 1'b0, '0},
      '{ROW_WORD,     REQ_LOAD,   8'h3C, 1'b0, 1'b1, flags_only(1'b1, 1'b0, 1'b0)},
      '{ROW_WORD,     REQ_STOP,   8'h00, 1'b0, 1'b1, flags_only(1'b0, 1'b0, 1'b0)},
      '{ROW_WORD,     REQ_LOAD,   8'hC3, 1'b1, 1'b1, flags_only(1'b1, 1'b1, 1'b0)},
      '{ROW_WORD,     REQ_LOAD,   8'h77, 1'b0, 1'b1, flags_only(1'b1, 1'b1, 1'b0)},
      '{ROW_WORD,     REQ_TICK,   8'h00, 1'b0, 1'b0, '0},
      '{ROW_WORD,     REQ_LOAD,   8'h88, 1'b0, 1'b1, flags_only(1'b1, 1'b0, 1'b0)},
      '{ROW_WORD,     REQ_LOAD,   8'h99, 1'b1, 1'b1, flags_only(1'b1, 1'b0, 1'b1)},
      '{ROW_WORD,     REQ_TICK,   8'h00, 1'b0, 1'b0, '0},
      '{ROW_WORD,     REQ_LOAD,   8'h42, 1'b1, 1'b1, flags_only(1'b1, 1'b1, 1'b1)},
      '{ROW_WORD,     REQ_TICK,   8'h00, 1'b0, 1'b0, '0},
      '{ROW_WORD,     REQ_STOP,   8'hFF, 1'b1, 1'b1, flags_only(1'b0, 1'b0, 1'b0)},
      '{ROW_SET_FILL, REQ_LOAD,   8'h00, 1'b0, 1'b0, '0},
      '{ROW_WORD,     REQ_LOAD,   8'hEE, 1'b1, 1'b1, flags_only(1'b0, 1'b0, 1'b0)},
      '{ROW_WORD,     REQ_TICK,   8'h00, 1'b0, 1'b1, flags_only(1'b0, 1'b0, 1'b0)},
      '{ROW_SET_FILL, REQ_LOAD,   8'h00, 1'b1, 1'b0, '0},
      '{ROW_WORD,     REQ_LOAD,   8'h01, 1'b1, 1'b1, flags_only(1'b1, 1'b1, 1'b0)},
      '{ROW_WORD,     REQ_TICK,   8'h00, 1'b0, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[ROW_AW'(i)];
      if (row.kind == ROW_SET_FILL)
        program_fill_enable(row.flag);
      else
        send_word(row.req, row.data, row.flag, row.typed, row.want);
    end

    // Random traffic: the first phase opens with a fill that runs a buffer full.
    play_random(600, 1'b1);
    program_fill_enable(1'b0);
    play_random(60, 1'b0);
    program_fill_enable(1'b1);
    play_random(865, 1'b0);

    settle();
    repeat (8) @(posedge clk);

    $display("Sent %0d input words and checked %0d output words.", words_sent, words_checked);
    $display("Played %0d byte pairs and ran %0d buffers dry.", pairs_played, buffers_freed);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ppap_pkg.sv
hw/rtl/pingpong_audio_playout.sv
dv/testbench.sv
